// ----- src/id_number_validator_unit_defines.svh -----
// Assertion helpers for the ID number validator.
// Both sample on clk and are switched off while rst is high.
`ifndef ID_NUMBER_VALIDATOR_UNIT_DEFINES_SVH
`define ID_NUMBER_VALIDATOR_UNIT_DEFINES_SVH

// Same-cycle implication.
`define IDNV_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("idnv assertion failed");

// Next-cycle implication.
`define IDNV_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("idnv assertion failed");

`endif

// ----- src/idnv_pkg.sv -----
`timescale 1ns / 1ps

package idnv_pkg;

  // Character positions, counted from zero
  localparam logic [4:0] POS_YEAR_FIRST  = 5'd6;
  localparam logic [4:0] POS_YEAR_LAST   = 5'd9;
  localparam logic [4:0] POS_MONTH_FIRST = 5'd10;
  localparam logic [4:0] POS_MONTH_LAST  = 5'd11;
  localparam logic [4:0] POS_DAY_FIRST   = 5'd12;
  localparam logic [4:0] POS_DAY_LAST    = 5'd13;
  localparam logic [4:0] POS_SEX         = 5'd16;
  localparam logic [4:0] POS_CHECK       = 5'd17;
  localparam logic [4:0] COUNT_MAX       = 5'd31;

  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;

  localparam logic [13:0] AGE_LIMIT       = 14'd130;
  localparam logic [13:0] BASE_YEAR       = 14'd1900;
  localparam logic [3:0]  BASE_YEAR_MOD12 = 4'd4;
  localparam logic [3:0]  ANIMAL_NONE     = 4'd12;
  localparam logic [8:0]  DAYS_LEAP       = 9'd366;
  localparam logic [8:0]  DAYS_NORM       = 9'd365;

  // Configuration register indexes and reset values
  localparam logic [1:0] REG_YEAR  = 2'd0;
  localparam logic [1:0] REG_MONTH = 2'd1;
  localparam logic [1:0] REG_DAY   = 2'd2;

  localparam logic [13:0] RESET_YEAR  = 14'd2024;
  localparam logic [3:0]  RESET_MONTH = 4'd1;
  localparam logic [4:0]  RESET_DAY   = 5'd1;

  // Captured accumulator contents of one finished number
  typedef struct packed {
    logic        len_ok;
    logic        bad_digit;
    logic [3:0]  sum_mod11;
    logic [7:0]  check_char;
    logic [13:0] year;
    logic [8:0]  year_mod400;
    logic [3:0]  year_mod12;
    logic [6:0]  month;
    logic [6:0]  day;
    logic        sex_odd;
  } snap_t;

  // Decoded values ahead of the birthday distance
  typedef struct packed {
    logic        len_ok;
    logic        ck_ok;
    logic        yr_ok;
    logic [13:0] year;
    logic [6:0]  month;
    logic [6:0]  day;
    logic        sex_odd;
    logic [14:0] age;
    logic        leap;
    logic [8:0]  today;
    logic [8:0]  bday;
    logic [3:0]  animal;
  } mid_t;

  // Digit weights of positions 0..16
  function automatic logic [3:0] digit_weight(input logic [4:0] pos);
    logic [3:0] w;
    case (pos)
      5'd0, 5'd10:  w = 4'd7;
      5'd1, 5'd11:  w = 4'd9;
      5'd2, 5'd12:  w = 4'd10;
      5'd3, 5'd13:  w = 4'd5;
      5'd4, 5'd14:  w = 4'd8;
      5'd5, 5'd15:  w = 4'd4;
      5'd6, 5'd16:  w = 4'd2;
      5'd7:         w = 4'd1;
      5'd8:         w = 4'd6;
      5'd9:         w = 4'd3;
      default:      w = 4'd0;
    endcase
    return w;
  endfunction

  // Expected check character for a sum residue
  function automatic logic [7:0] check_code(input logic [3:0] r);
    logic [7:0] c;
    case (r)
      4'd0:    c = 8'h31;
      4'd1:    c = 8'h30;
      4'd2:    c = 8'h58;
      4'd3:    c = 8'h39;
      4'd4:    c = 8'h38;
      4'd5:    c = 8'h37;
      4'd6:    c = 8'h36;
      4'd7:    c = 8'h35;
      4'd8:    c = 8'h34;
      4'd9:    c = 8'h33;
      4'd10:   c = 8'h32;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // Days before the first of a month, month index 0..11
  function automatic logic [8:0] cum_days(input logic [3:0] idx, input logic leap);
    logic [8:0] n;
    case (idx)
      4'd0:    n = 9'd0;
      4'd1:    n = 9'd31;
      4'd2:    n = 9'd59;
      4'd3:    n = 9'd90;
      4'd4:    n = 9'd120;
      4'd5:    n = 9'd151;
      4'd6:    n = 9'd181;
      4'd7:    n = 9'd212;
      4'd8:    n = 9'd243;
      4'd9:    n = 9'd273;
      4'd10:   n = 9'd304;
      4'd11:   n = 9'd334;
      default: n = 9'd0;
    endcase
    if (leap && (idx >= 4'd2) && (idx <= 4'd11)) begin
      n = n + 9'd1;
    end
    return n;
  endfunction

  // Day of year; a month outside 1..12 gives zero
  function automatic logic [8:0] day_of_year(input logic [6:0] mon, input logic [6:0] day,
                                             input logic leap);
    logic [8:0] n;
    if ((mon == 7'd0) || (mon > 7'd12)) begin
      n = 9'd0;
    end else begin
      n = cum_days(mon[3:0] - 4'd1, leap) + {2'b00, day};
    end
    return n;
  endfunction

  // Residue mod 11 of a value up to 100
  function automatic logic [3:0] mod11_small(input logic [6:0] v);
    logic [6:0] t;
    t = v;
    if (t >= 7'd88) t = t - 7'd88;
    if (t >= 7'd44) t = t - 7'd44;
    if (t >= 7'd22) t = t - 7'd22;
    if (t >= 7'd11) t = t - 7'd11;
    return t[3:0];
  endfunction

  // Residue mod 12 of a value up to 119
  function automatic logic [3:0] mod12_small(input logic [6:0] v);
    logic [6:0] t;
    t = v;
    if (t >= 7'd96) t = t - 7'd96;
    if (t >= 7'd48) t = t - 7'd48;
    if (t >= 7'd24) t = t - 7'd24;
    if (t >= 7'd12) t = t - 7'd12;
    return t[3:0];
  endfunction

  // Residue mod 400 of a value up to 3999
  function automatic logic [8:0] mod400_small(input logic [11:0] v);
    logic [11:0] t;
    t = v;
    if (t >= 12'd3200) t = t - 12'd3200;
    if (t >= 12'd1600) t = t - 12'd1600;
    if (t >= 12'd800)  t = t - 12'd800;
    if (t >= 12'd400)  t = t - 12'd400;
    return t[8:0];
  endfunction

endpackage

// ----- src/id_number_validator_unit.sv -----
`timescale 1ns / 1ps
// ID number validator: one ASCII character accepted per cycle while s_axis_tready is high,
// no gaps needed. The snapshot is taken at the edge that accepts the last character, then
// the decode and result registers follow before m_axis_tvalid rises.
// Throughput: one character per cycle, one result per number; s_axis_tready drops
// only while snapshot, decode and result registers all hold numbers and m_axis_tready is low.
// rst (synchronous) clears accumulators and pipeline valids and loads the
// configuration defaults (year 2024, January 1).
`include "id_number_validator_unit_defines.svh"

module id_number_validator_unit (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [13:0] cfg_data,
  // character stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] id_char
  input  logic        s_axis_tlast,   // last_char
  // results
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata    // [0] valid_res, [1] length_ok, [2] checksum_ok,
                                      // [3] year_ok, [17:4] birth_year,
                                      // [24:18] birth_month, [31:25] birth_day,
                                      // [32] is_male, [47:33] age_years,
                                      // [56:48] days_to_birthday, [60:57] animal_sign,
                                      // [63:61] zero
);

  // Configuration registers
  logic [13:0] current_year;
  logic [3:0]  current_month;
  logic [4:0]  current_day;

  always_ff @(posedge clk) begin
    if (rst) begin
      current_year  <= idnv_pkg::RESET_YEAR;
      current_month <= idnv_pkg::RESET_MONTH;
      current_day   <= idnv_pkg::RESET_DAY;
    end else if (cfg_we) begin
      case (cfg_index)
        idnv_pkg::REG_YEAR:  current_year  <= cfg_data;
        idnv_pkg::REG_MONTH: current_month <= cfg_data[3:0];
        idnv_pkg::REG_DAY:   current_day   <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // Pipeline flow control
  logic snap_valid, mid_valid, out_valid;
  logic load_out, load_mid, in_xfer;

  assign load_out      = mid_valid && (!out_valid || m_axis_tready);
  assign load_mid      = snap_valid && (!mid_valid || load_out);
  assign s_axis_tready = !snap_valid || load_mid;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  // Character accumulators
  logic [4:0]  char_count;
  logic [3:0]  sum_mod11;
  logic [13:0] year_acc;
  logic [8:0]  year_mod400;
  logic [3:0]  year_mod12;
  logic [6:0]  month_acc;
  logic [6:0]  day_acc;
  logic        sex_odd;
  logic        bad_digit;
  logic [7:0]  check_char;

  logic [3:0]  sum_mod11_next;
  logic [13:0] year_acc_next;
  logic [8:0]  year_mod400_next;
  logic [3:0]  year_mod12_next;
  logic [6:0]  month_acc_next;
  logic [6:0]  day_acc_next;
  logic        sex_odd_next;
  logic        bad_digit_next;
  logic [7:0]  check_char_next;

  logic        is_digit;
  logic [3:0]  digit;
  logic [7:0]  wprod;
  logic [16:0] year_x10;
  logic [11:0] mod400_x10;
  logic [6:0]  mod12_x10;
  logic [9:0]  month_x10;
  logic [9:0]  day_x10;

  always_comb begin
    is_digit   = (s_axis_tdata >= idnv_pkg::CHAR_ZERO) && (s_axis_tdata <= idnv_pkg::CHAR_NINE);
    digit      = is_digit ? 4'(s_axis_tdata - idnv_pkg::CHAR_ZERO) : 4'd0;
    wprod      = 8'(digit * idnv_pkg::digit_weight(char_count));
    year_x10   = {year_acc, 3'b000} + {2'b00, year_acc, 1'b0} + {13'd0, digit};
    mod400_x10 = {year_mod400, 3'b000} + {2'b00, year_mod400, 1'b0} + {8'd0, digit};
    mod12_x10  = {year_mod12[3:0], 3'b000} + {2'b00, year_mod12[3:0], 1'b0}
                 + {3'd0, digit};
    month_x10  = {month_acc, 3'b000} + {2'b00, month_acc, 1'b0} + {6'd0, digit};
    day_x10    = {day_acc, 3'b000} + {2'b00, day_acc, 1'b0} + {6'd0, digit};

    sum_mod11_next   = sum_mod11;
    year_acc_next    = year_acc;
    year_mod400_next = year_mod400;
    year_mod12_next  = year_mod12;
    month_acc_next   = month_acc;
    day_acc_next     = day_acc;
    sex_odd_next     = sex_odd;
    bad_digit_next   = bad_digit;
    check_char_next  = check_char;

    if (char_count < idnv_pkg::POS_CHECK) begin
      if (!is_digit) begin
        bad_digit_next = 1'b1;
      end
      sum_mod11_next = idnv_pkg::mod11_small(7'({3'd0, sum_mod11} + wprod));
      if ((char_count >= idnv_pkg::POS_YEAR_FIRST) && (char_count <= idnv_pkg::POS_YEAR_LAST)) begin
        year_acc_next    = year_x10[13:0];
        year_mod400_next = idnv_pkg::mod400_small(mod400_x10);
        year_mod12_next  = idnv_pkg::mod12_small(mod12_x10);
      end else if ((char_count == idnv_pkg::POS_MONTH_FIRST) ||
                   (char_count == idnv_pkg::POS_MONTH_LAST)) begin
        month_acc_next = month_x10[6:0];
      end else if ((char_count == idnv_pkg::POS_DAY_FIRST) ||
                   (char_count == idnv_pkg::POS_DAY_LAST)) begin
        day_acc_next = day_x10[6:0];
      end else if (char_count == idnv_pkg::POS_SEX) begin
        sex_odd_next = digit[0];
      end
    end else if (char_count == idnv_pkg::POS_CHECK) begin
      check_char_next = s_axis_tdata;
    end
  end

  // Accumulators advance on every transfer and clear after the last character
  always_ff @(posedge clk) begin
    if (rst) begin
      char_count  <= '0;
      sum_mod11   <= '0;
      year_acc    <= '0;
      year_mod400 <= '0;
      year_mod12  <= '0;
      month_acc   <= '0;
      day_acc     <= '0;
      sex_odd     <= 1'b0;
      bad_digit   <= 1'b0;
      check_char  <= '0;
    end else if (in_xfer) begin
      if (s_axis_tlast) begin
        char_count  <= '0;
        sum_mod11   <= '0;
        year_acc    <= '0;
        year_mod400 <= '0;
        year_mod12  <= '0;
        month_acc   <= '0;
        day_acc     <= '0;
        sex_odd     <= 1'b0;
        bad_digit   <= 1'b0;
        check_char  <= '0;
      end else begin
        if (char_count != idnv_pkg::COUNT_MAX) begin
          char_count <= char_count + 5'd1;
        end
        sum_mod11   <= sum_mod11_next;
        year_acc    <= year_acc_next;
        year_mod400 <= year_mod400_next;
        year_mod12  <= year_mod12_next;
        month_acc   <= month_acc_next;
        day_acc     <= day_acc_next;
        sex_odd     <= sex_odd_next;
        bad_digit   <= bad_digit_next;
        check_char  <= check_char_next;
      end
    end
  end

  // Stage 1: capture the finished number
  idnv_pkg::snap_t snap;

  always_ff @(posedge clk) begin
    if (rst) begin
      snap_valid <= 1'b0;
    end else if (in_xfer && s_axis_tlast) begin
      snap_valid <= 1'b1;
    end else if (load_mid) begin
      snap_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && s_axis_tlast) begin
      snap.len_ok      <= (char_count == idnv_pkg::POS_CHECK);
      snap.bad_digit   <= bad_digit_next;
      snap.sum_mod11   <= sum_mod11_next;
      snap.check_char  <= check_char_next;
      snap.year        <= year_acc_next;
      snap.year_mod400 <= year_mod400_next;
      snap.year_mod12  <= year_mod12_next;
      snap.month       <= month_acc_next;
      snap.day         <= day_acc_next;
      snap.sex_odd     <= sex_odd_next;
    end
  end

  // Stage 2: checksum, age, leap rule, days of year, animal sign
  idnv_pkg::snap_t snap_in;
  idnv_pkg::mid_t  mid_next;
  idnv_pkg::mid_t  mid;
  logic            leap;
  logic            century;

  always_comb begin
    snap_in = snap;
    century = (snap_in.year_mod400 == 9'd0) || (snap_in.year_mod400 == 9'd100) ||
              (snap_in.year_mod400 == 9'd200) || (snap_in.year_mod400 == 9'd300);
    leap    = ((snap_in.year[1:0] == 2'b00) && !century) || (snap_in.year_mod400 == 9'd0);

    mid_next.len_ok  = snap_in.len_ok;
    mid_next.ck_ok   = snap_in.len_ok && !snap_in.bad_digit &&
                       (idnv_pkg::check_code(snap_in.sum_mod11) == snap_in.check_char);
    mid_next.age     = {1'b0, current_year} - {1'b0, snap_in.year};
    mid_next.yr_ok   = !mid_next.age[14] && (mid_next.age[13:0] < idnv_pkg::AGE_LIMIT);
    mid_next.year    = snap_in.year;
    mid_next.month   = snap_in.month;
    mid_next.day     = snap_in.day;
    mid_next.sex_odd = snap_in.sex_odd;
    mid_next.leap    = leap;
    mid_next.today   = idnv_pkg::day_of_year({3'd0, current_month}, {2'd0, current_day}, leap);
    mid_next.bday    = idnv_pkg::day_of_year(snap_in.month, snap_in.day, leap);
    if (snap_in.year < idnv_pkg::BASE_YEAR) begin
      mid_next.animal = idnv_pkg::ANIMAL_NONE;
    end else if (snap_in.year_mod12 >= idnv_pkg::BASE_YEAR_MOD12) begin
      mid_next.animal = snap_in.year_mod12 - idnv_pkg::BASE_YEAR_MOD12;
    end else begin
      mid_next.animal = snap_in.year_mod12 + (4'd12 - idnv_pkg::BASE_YEAR_MOD12);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
    end else if (load_mid) begin
      mid_valid <= 1'b1;
    end else if (load_out) begin
      mid_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_mid) begin
      mid <= mid_next;
    end
  end

  // Stage 3: days to the next birthday and result packing
  logic [8:0]  togo;
  logic [63:0] out_next;

  always_comb begin
    if (mid.bday > mid.today) begin
      togo = mid.bday - mid.today;
    end else begin
      togo = (mid.leap ? idnv_pkg::DAYS_LEAP : idnv_pkg::DAYS_NORM) - mid.today + mid.bday;
    end
    out_next = {3'b000, mid.animal, togo, mid.age, mid.sex_odd, mid.day, mid.month,
                mid.year, mid.yr_ok, mid.ck_ok, mid.len_ok,
                mid.len_ok && mid.ck_ok && mid.yr_ok};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_axis_tdata <= out_next;
    end
  end

  assign m_axis_tvalid = out_valid;

  // Checks
  `IDNV_ASSERT_NOW(a_valid_needs_all, m_axis_tvalid && m_axis_tdata[0], m_axis_tdata[1] && m_axis_tdata[2] && m_axis_tdata[3])
  `IDNV_ASSERT_NOW(a_ck_needs_len, m_axis_tvalid && m_axis_tdata[2], m_axis_tdata[1])
  `IDNV_ASSERT_NEXT(a_clear_after_last, in_xfer && s_axis_tlast, (char_count == 5'd0) && snap_valid)
  `IDNV_ASSERT_NOW(a_animal_range, m_axis_tvalid, m_axis_tdata[60:57] <= idnv_pkg::ANIMAL_NONE)

endmodule
